>>> hdl/latency_histogram_double_buffered_defines.svh
// ----------------------------------------------------------------------------
// Latency histogram assertion macros
// Shared property templates for the checker of the histogram block.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_DOUBLE_BUFFERED_DEFINES_SVH
`define LATENCY_HISTOGRAM_DOUBLE_BUFFERED_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LHDB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lhdb check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LHDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lhdb check failed");

`endif

>>> hdl/lhdb_pkg.sv
// ----------------------------------------------------------------------------
// Latency histogram package
// Commands, queue item type and the fixed sizes of the histogram.
// ----------------------------------------------------------------------------
package lhdb_pkg;

    localparam int unsigned NUM_BUCKETS   = 4096;
    localparam int unsigned COUNT_WIDTH   = 32;
    localparam int unsigned NS_PER_BUCKET = 1000;

    localparam int unsigned BANK_SIZE = NUM_BUCKETS + 1;
    localparam int unsigned IDX_W     = 13;
    localparam int unsigned NS_W      = 48;
    localparam int unsigned MEM_DEPTH = 2 * BANK_SIZE;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

    // Latencies at or above NS_LIMIT land in the overflow bucket. Below it the
    // quotient is a multiply by a rounded-up reciprocal, exact over this range.
    localparam longint unsigned NS_LIMIT    = longint'(NUM_BUCKETS) * NS_PER_BUCKET;
    localparam int unsigned     NS_BITS     = $clog2(NS_LIMIT);
    localparam int unsigned     RECIP_SHIFT = 32;
    localparam longint unsigned RECIP =
        ((longint'(1) << RECIP_SHIFT) + NS_PER_BUCKET - 1) / NS_PER_BUCKET;
    localparam int unsigned     RECIP_BITS  = $clog2(RECIP + 1);

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_FLIP   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
    } t_item;

endpackage

>>> hdl/latency_histogram_double_buffered.sv
// ----------------------------------------------------------------------------
// Double-buffered latency histogram
// Two banks of saturating microsecond-bucket counters; samples go to the
// current bank, a new trial swaps banks and reads come from the finished one.
//
//   Channel   Handshake           Payload
//   input     i_valid / o_stall   i_command, i_latency_ns, i_read_index
//   output    o_valid / i_stall   o_bucket_index, o_bucket_count, o_used_extent
//
// Record and read beats each pass through a registered read of the
// single-port counter memory, then the update and the result register.
// A new trial clears the used prefix and the overflow bucket of the new
// current bank when that bank holds samples.
// After reset the counter memory is swept to zero while o_stall stays high.
// A stalled result holds the back end; the queue keeps taking input beats
// until it fills.
// ----------------------------------------------------------------------------
module latency_histogram_double_buffered #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_command,
    input  logic [lhdb_pkg::NS_W-1:0]           i_latency_ns,
    input  logic [lhdb_pkg::IDX_W-1:0]          i_read_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lhdb_pkg::IDX_W-1:0]          o_bucket_index,
    output logic [lhdb_pkg::COUNT_WIDTH-1:0]    o_bucket_count,
    output logic [lhdb_pkg::IDX_W-1:0]          o_used_extent
);
    import lhdb_pkg::*;

    logic   w_push;
    t_item  w_item;
    logic   w_q_full;
    logic   w_pop;
    t_item  w_head;
    logic   w_not_empty;
    logic   w_init_busy;

    lhdb_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_latency_ns (i_latency_ns),
        .i_read_index (i_read_index),
        .i_q_full     (w_q_full),
        .i_init_busy  (w_init_busy),
        .o_push       (w_push),
        .o_item       (w_item)
    );

    lhdb_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_item),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_not_empty (w_not_empty)
    );

    lhdb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_not_empty    (w_not_empty),
        .o_pop          (w_pop),
        .o_init_busy    (w_init_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_bucket_index (o_bucket_index),
        .o_bucket_count (o_bucket_count),
        .o_used_extent  (o_used_extent)
    );

endmodule

>>> hdl/lhdb_front.sv
// ----------------------------------------------------------------------------
// Latency histogram front end
// Accepts input beats and turns each into a command and a bucket index.
// ----------------------------------------------------------------------------
module lhdb_front (
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_command,
    input  logic [lhdb_pkg::NS_W-1:0]           i_latency_ns,
    input  logic [lhdb_pkg::IDX_W-1:0]          i_read_index,
    input  logic                                i_q_full,
    input  logic                                i_init_busy,
    output logic                                o_push,
    output lhdb_pkg::t_item                     o_item
);
    import lhdb_pkg::*;

    localparam int unsigned PROD_W = NS_BITS + RECIP_BITS;

    logic [NS_BITS-1:0]    w_ns_low;
    logic [PROD_W-1:0]     w_prod;
    logic                  w_ovf;
    logic [IDX_W-1:0]      w_bucket;
    logic [IDX_W-1:0]      w_read_sat;
    t_cmd                  w_cmd;

    assign o_stall = i_q_full || i_init_busy;
    assign o_push  = i_valid && !o_stall;

    assign w_cmd    = t_cmd'(i_command);
    assign w_ovf    = i_latency_ns >= NS_W'(NS_LIMIT);
    assign w_ns_low = i_latency_ns[NS_BITS-1:0];
    assign w_prod   = {{RECIP_BITS{1'b0}}, w_ns_low} * {{NS_BITS{1'b0}}, RECIP_BITS'(RECIP)};
    assign w_bucket = w_ovf ? IDX_W'(NUM_BUCKETS) : w_prod[RECIP_SHIFT +: IDX_W];

    assign w_read_sat = (i_read_index > IDX_W'(NUM_BUCKETS)) ? IDX_W'(NUM_BUCKETS)
                                                              : i_read_index;

    always_comb begin
        o_item.cmd = w_cmd;
        unique case (w_cmd)
            CMD_RECORD: o_item.idx = w_bucket;
            CMD_READ:   o_item.idx = w_read_sat;
            CMD_FLIP,
            CMD_NONE:   o_item.idx = '0;
            default:    o_item.idx = '0;
        endcase
    end

endmodule

>>> hdl/lhdb_queue.sv
// ----------------------------------------------------------------------------
// Latency histogram command queue
// Small FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module lhdb_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lhdb_pkg::t_item   i_item,
    output logic              o_full,
    input  logic              i_pop,
    output lhdb_pkg::t_item   o_head,
    output logic              o_not_empty
);
    import lhdb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full      = r_count == CNT_W'(DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_head      = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> hdl/lhdb_back.sv
// ----------------------------------------------------------------------------
// Latency histogram back end
// Owns the two counter banks in one memory, runs the reset sweep and the
// per-trial clear, and holds the result register.
// ----------------------------------------------------------------------------
module lhdb_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lhdb_pkg::t_item                     i_head,
    input  logic                                i_not_empty,
    output logic                                o_pop,
    output logic                                o_init_busy,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lhdb_pkg::IDX_W-1:0]          o_bucket_index,
    output logic [lhdb_pkg::COUNT_WIDTH-1:0]    o_bucket_count,
    output logic [lhdb_pkg::IDX_W-1:0]          o_used_extent
);
    import lhdb_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_EXEC
    } t_state;

    t_state                 r_state;
    logic                   r_cur_bank;
    logic [IDX_W-1:0]       r_ext_cur;
    logic [IDX_W-1:0]       r_ext_fin;
    t_cmd                   r_cmd;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_clr_cnt;
    logic [IDX_W-1:0]       r_clr_ext;
    logic [ADDR_W-1:0]      r_sweep;
    logic                   r_out_valid;
    logic [IDX_W-1:0]       r_out_idx;
    logic [COUNT_WIDTH-1:0] r_out_cnt;
    logic [IDX_W-1:0]       r_out_ext;

    logic [COUNT_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [COUNT_WIDTH-1:0] w_wdata;
    logic [ADDR_W-1:0]      w_raddr;
    logic [IDX_W-1:0]       w_clr_idx;
    logic                   w_clr_last;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic [IDX_W-1:0]       w_idx_p1;
    logic [IDX_W-1:0]       w_new_ext;
    logic                   w_out_free;

    function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
                                                    input logic [IDX_W-1:0] idx);
        bank_addr = bank ? ADDR_W'(BANK_SIZE) + ADDR_W'(idx) : ADDR_W'(idx);
    endfunction

    assign o_init_busy    = r_state == S_INIT;
    assign o_pop          = (r_state == S_IDLE) && i_not_empty;
    assign o_valid        = r_out_valid;
    assign o_bucket_index = r_out_idx;
    assign o_bucket_count = r_out_cnt;
    assign o_used_extent  = r_out_ext;

    assign w_out_free = !r_out_valid || !i_stall;

    // The clear walks the used prefix, then finishes on the overflow bucket.
    assign w_clr_last = r_clr_cnt == r_clr_ext;
    assign w_clr_idx  = w_clr_last ? IDX_W'(NUM_BUCKETS) : r_clr_cnt;

    assign w_inc     = (&r_rd_data) ? r_rd_data : r_rd_data + 1'b1;
    assign w_idx_p1  = r_idx + 1'b1;
    assign w_new_ext = (r_ext_cur < w_idx_p1) ? w_idx_p1 : r_ext_cur;

    // A read command looks at the finished bank, everything else at the current one.
    assign w_raddr = bank_addr((i_head.cmd == CMD_READ) ? !r_cur_bank : r_cur_bank,
                               i_head.idx);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = bank_addr(r_cur_bank, w_clr_idx);
            end
            S_EXEC: begin
                if (w_out_free && (r_cmd == CMD_RECORD)) begin
                    w_we    = 1'b1;
                    w_waddr = bank_addr(r_cur_bank, r_idx);
                    w_wdata = w_inc;
                end
            end
            S_IDLE: begin
                w_we = 1'b0;
            end
        endcase
    end

    // The read data is loaded only when a beat is taken from the queue, so it
    // holds while a result waits at the output.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cur_bank  <= 1'b0;
            r_ext_cur   <= '0;
            r_ext_fin   <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EXEC) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == ADDR_W'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_not_empty) begin
                        r_cmd     <= i_head.cmd;
                        r_idx     <= i_head.idx;
                        if (i_head.cmd == CMD_FLIP) begin
                            // Banks swap roles; the new current bank starts empty.
                            r_cur_bank <= !r_cur_bank;
                            r_ext_fin  <= r_ext_cur;
                            r_ext_cur  <= '0;
                            r_clr_ext  <= r_ext_fin;
                            r_clr_cnt  <= '0;
                            r_state    <= (r_ext_fin != '0) ? S_CLEAR : S_EXEC;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (w_clr_last) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        case (r_cmd)
                            CMD_RECORD: begin
                                r_out_idx <= r_idx;
                                r_out_cnt <= w_inc;
                                r_out_ext <= w_new_ext;
                                r_ext_cur <= w_new_ext;
                            end
                            CMD_READ: begin
                                r_out_idx <= r_idx;
                                r_out_cnt <= r_rd_data;
                                r_out_ext <= r_ext_fin;
                            end
                            default: begin
                                r_out_idx <= '0;
                                r_out_cnt <= '0;
                                r_out_ext <= '0;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

>>> hdl/lhdb_checker.sv
// ----------------------------------------------------------------------------
// Latency histogram port checker
// Watches the top-level ports for reset sweep, result hold and range rules.
// ----------------------------------------------------------------------------
`include "latency_histogram_double_buffered_defines.svh"

module lhdb_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_stall,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic [lhdb_pkg::IDX_W-1:0]          o_bucket_index,
    input  logic [lhdb_pkg::COUNT_WIDTH-1:0]    o_bucket_count,
    input  logic [lhdb_pkg::IDX_W-1:0]          o_used_extent
);
    import lhdb_pkg::*;

    // The memory sweep must hold off input right after reset.
    `LHDB_ASSERT_IMPLY(a_init_stall, i_clk, i_rst_n, !$past(i_rst_n), o_stall)

    `LHDB_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    `LHDB_ASSERT_NEXT(a_beat_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_bucket_index) && $stable(o_bucket_count) && $stable(o_used_extent))

    // Bucket numbers never pass the overflow bucket, extents never pass the bank.
    `LHDB_ASSERT_IMPLY(a_ranges, i_clk, i_rst_n, o_valid, (o_bucket_index <= IDX_W'(NUM_BUCKETS)) && (o_used_extent <= IDX_W'(BANK_SIZE)))

endmodule

bind latency_histogram_double_buffered lhdb_checker u_lhdb_checker (.*);

>>> tb/latency_histogram_double_buffered_tb.sv
// ----------------------------------------------------------------------------
// Double-buffered latency histogram testbench
// Sends record, new-trial, read and unused command beats with random gaps,
// stalls the result channel on its own pattern, and checks every result beat
// against a model of the two counter banks that is kept alongside the block.
// ----------------------------------------------------------------------------
module latency_histogram_double_buffered_tb;

    import lhdb_pkg::*;

    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        t_cmd             cmd;
        logic [NS_W-1:0]  ns;
        logic [IDX_W-1:0] ridx;
        bit               drain;
    } t_hist_cmd;

    typedef struct {
        logic [IDX_W-1:0]       bucket;
        logic [COUNT_WIDTH-1:0] count;
        logic [IDX_W-1:0]       extent;
    } t_bin_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [1:0]             i_command = CMD_NONE;
    logic [NS_W-1:0]        i_latency_ns = '0;
    logic [IDX_W-1:0]       i_read_index = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [IDX_W-1:0]       o_bucket_index;
    logic [COUNT_WIDTH-1:0] o_bucket_count;
    logic [IDX_W-1:0]       o_used_extent;

    // Model of the counter banks.
    logic [COUNT_WIDTH-1:0] bin_count [2][BANK_SIZE];
    logic [IDX_W-1:0]       bank_extent [2];
    bit                     live_bank;

    t_hist_cmd   pending_cmds[$];
    t_bin_report bin_results_due[$];

    logic in_taken = 1'b0;
    int   total_cmds = 0;
    int   beats_taken = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_mode = 0;
    int   stall_left = 0;

    latency_histogram_double_buffered dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_latency_ns   (i_latency_ns),
        .i_read_index   (i_read_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_bucket_index (o_bucket_index),
        .o_bucket_count (o_bucket_count),
        .o_used_extent  (o_used_extent)
    );

    always #5 i_clk = ~i_clk;

    function automatic void queue_cmd(t_cmd c, longint unsigned ns, int unsigned ridx,
                                      bit drain = 1'b0);
        t_hist_cmd h;
        h.cmd   = c;
        h.ns    = ns[NS_W-1:0];
        h.ridx  = ridx[IDX_W-1:0];
        h.drain = drain;
        pending_cmds.push_back(h);
    endfunction

    function automatic t_bin_report histogram_apply(t_cmd cmd, logic [NS_W-1:0] ns,
                                                    logic [IDX_W-1:0] ridx);
        t_bin_report     r;
        longint unsigned quot;
        int unsigned     bkt;
        bit              other;
        r = '{bucket: '0, count: '0, extent: '0};
        other = ~live_bank;
        case (cmd)
            CMD_RECORD: begin
                quot = 64'(ns) / 64'(NS_PER_BUCKET);
                bkt = (quot >= 64'(NUM_BUCKETS)) ? NUM_BUCKETS : 32'(quot);
                if (bin_count[live_bank][bkt] != '1) begin
                    bin_count[live_bank][bkt] = bin_count[live_bank][bkt] + 1'b1;
                end
                if (32'(bank_extent[live_bank]) < bkt + 1) begin
                    bank_extent[live_bank] = IDX_W'(bkt + 1);
                end
                r = '{bucket: bkt[IDX_W-1:0], count: bin_count[live_bank][bkt],
                      extent: bank_extent[live_bank]};
            end
            CMD_FLIP: begin
                // Only the used prefix and the overflow bucket get cleared.
                if (bank_extent[other] != '0) begin
                    for (int i = 0; i < int'(bank_extent[other]); i++) begin
                        bin_count[other][i] = '0;
                    end
                    bin_count[other][NUM_BUCKETS] = '0;
                    bank_extent[other] = '0;
                end
                live_bank = other;
            end
            CMD_READ: begin
                bkt = (32'(ridx) > NUM_BUCKETS) ? NUM_BUCKETS : 32'(ridx);
                r = '{bucket: bkt[IDX_W-1:0], count: bin_count[other][bkt],
                      extent: bank_extent[other]};
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    // Sender: bursts of random length with random gaps. A beat marked drain
    // waits until every outstanding result has come back.
    always @(negedge i_clk) begin
        t_hist_cmd h;
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    burst_left = $urandom_range(100, 300);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = $urandom_range(1, 8);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].drain && bin_results_due.size() != 0)) begin
                h = pending_cmds.pop_front();
                burst_left--;
                i_valid      <= 1'b1;
                i_command    <= h.cmd;
                i_latency_ns <= h.ns;
                i_read_index <= h.ridx;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall phases of random length, from never to nearly always.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 1) == 1);
            default: i_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_bin_report got;
        t_bin_report want;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{bucket: o_bucket_index, count: o_bucket_count,
                        extent: o_used_extent};
                if (bin_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result beat with nothing expected: bucket %0d count %0d",
                                 got.bucket, got.count);
                    end
                end else begin
                    want = bin_results_due.pop_front();
                    if (got.bucket !== want.bucket) begin
                        flag_mismatch("bucket_index", want.bucket, got.bucket);
                    end
                    if (got.count !== want.count) begin
                        flag_mismatch("bucket_count", want.count, got.count);
                    end
                    if (got.extent !== want.extent) begin
                        flag_mismatch("used_extent", want.extent, got.extent);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                bin_results_due.push_back(histogram_apply(t_cmd'(i_command),
                                                          i_latency_ns, i_read_index));
                beats_taken++;
            end
            // The counter sweep after reset is the longest quiet stretch.
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int              trial_len;
        int              sel;
        bit              wide;
        longint unsigned ns;
        int unsigned     ridx;

        for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < BANK_SIZE; i++) begin
                bin_count[b][i] = '0;
            end
            bank_extent[b] = '0;
        end
        live_bank = 1'b0;

        // Directed: bucket edges, overflow, index saturation, unused command,
        // a new trial on an unused bank and a full clear of a used one.
        queue_cmd(CMD_READ, {$urandom, $urandom}, 0);
        queue_cmd(CMD_READ, {$urandom, $urandom}, 8191);
        queue_cmd(CMD_RECORD, 0, $urandom);
        queue_cmd(CMD_RECORD, 999, $urandom);
        queue_cmd(CMD_RECORD, 1000, $urandom);
        queue_cmd(CMD_RECORD, NS_LIMIT - 1, $urandom);
        queue_cmd(CMD_RECORD, NS_LIMIT, $urandom);
        queue_cmd(CMD_RECORD, 48'hFFFF_FFFF_FFFF, $urandom);
        queue_cmd(CMD_NONE, 48'hFFFF_FFFF_FFFF, 8191);
        queue_cmd(CMD_FLIP, {$urandom, $urandom}, $urandom, 1'b1);
        queue_cmd(CMD_READ, 0, 0);
        queue_cmd(CMD_READ, {$urandom, $urandom}, NUM_BUCKETS - 1);
        queue_cmd(CMD_READ, {$urandom, $urandom}, NUM_BUCKETS);
        queue_cmd(CMD_READ, {$urandom, $urandom}, NUM_BUCKETS + 1);
        queue_cmd(CMD_READ, {$urandom, $urandom}, 1);
        queue_cmd(CMD_RECORD, 5500, $urandom);
        queue_cmd(CMD_FLIP, {$urandom, $urandom}, $urandom);
        queue_cmd(CMD_READ, {$urandom, $urandom}, 5);
        queue_cmd(CMD_READ, {$urandom, $urandom}, 8191);
        queue_cmd(CMD_FLIP, {$urandom, $urandom}, $urandom, 1'b1);
        queue_cmd(CMD_READ, {$urandom, $urandom}, NUM_BUCKETS);
        queue_cmd(CMD_READ, {$urandom, $urandom}, 0);
        queue_cmd(CMD_RECORD, 0, $urandom);

        // Random trials: mostly short latencies, with a few wide trials that
        // spread into high buckets and overflow and so make the clear long.
        while (pending_cmds.size() < 950) begin
            trial_len = $urandom_range(5, 60);
            wide = ($urandom_range(0, 2) == 0);
            repeat (trial_len) begin
                sel = $urandom_range(0, 99);
                if (!wide || sel < 75) begin
                    ns = $urandom_range(0, 31999);
                end else if (sel < 88) begin
                    ns = $urandom_range(0, NS_LIMIT - 1);
                end else if (sel < 95) begin
                    ns = {$urandom, $urandom};
                end else begin
                    ns = NS_LIMIT - 1 + $urandom_range(0, 2);
                end
                sel = $urandom_range(0, 49);
                if (sel == 0) begin
                    queue_cmd(CMD_NONE, {$urandom, $urandom}, $urandom);
                end else if (sel < 4) begin
                    queue_cmd(CMD_READ, {$urandom, $urandom}, $urandom_range(0, 40));
                end else begin
                    queue_cmd(CMD_RECORD, ns, $urandom);
                end
            end
            queue_cmd(CMD_FLIP, {$urandom, $urandom}, $urandom, ($urandom_range(0, 5) == 0));
            repeat ($urandom_range(2, 12)) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    ridx = $urandom_range(0, 40);
                end else if (sel < 85) begin
                    ridx = $urandom_range(0, NUM_BUCKETS);
                end else begin
                    ridx = $urandom_range(0, 8191);
                end
                queue_cmd(CMD_READ, {$urandom, $urandom}, ridx);
            end
        end
        total_cmds = pending_cmds.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < total_cmds || bin_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (16) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
